>>> sv/sv39pmb_pkg.sv
// constants, types and control store for the sv39 page mapping builder
`default_nettype none
package sv39pmb_pkg;

	localparam int POOL_PAGES        = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int STORE_DEPTH       = POOL_PAGES * ENTRIES_PER_TABLE;

	localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
	localparam int PAGE_W  = $clog2(POOL_PAGES);
	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int PPN_W   = 44;
	localparam int VA_W    = 39;
	localparam int PA_W    = 56;
	localparam int PTE_W   = 64;
	localparam int FLAG_W  = 10;
	localparam int CNT_W   = 16;
	localparam int USE_W   = 4;
	localparam int PAGE_BYTES = 'h1000;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_OUTSIDE   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		STEP_CLEAR = 4'd0,
		STEP_IDLE  = 4'd1,
		STEP_CHECK = 4'd2,
		STEP_READ  = 4'd3,
		STEP_EVAL  = 4'd4,
		STEP_FOLW  = 4'd5,
		STEP_LEVEL = 4'd6,
		STEP_LEAF  = 4'd7,
		STEP_EMIT  = 4'd8
	} step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_PAGE,
		OP_READ,
		OP_EVAL,
		OP_FOLLOW,
		OP_LEVEL,
		OP_LEAF,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_CLR_LAST,
		C_ACCEPT,
		C_COUNT_DONE,
		C_EXHAUST,
		C_OUTSIDE,
		C_UPPER,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_true;
		step_t tgt_false;
	} uop_t;

	// microprogram
	function automatic uop_t ucode(input step_t step);
		uop_t u;
		case (step)
			STEP_CLEAR: u = '{OP_CLEAR,  C_CLR_LAST,   STEP_IDLE,  STEP_CLEAR};
			STEP_IDLE:  u = '{OP_LOAD,   C_ACCEPT,     STEP_CHECK, STEP_IDLE};
			STEP_CHECK: u = '{OP_PAGE,   C_COUNT_DONE, STEP_EMIT,  STEP_READ};
			STEP_READ:  u = '{OP_READ,   C_ALWAYS,     STEP_EVAL,  STEP_EVAL};
			STEP_EVAL:  u = '{OP_EVAL,   C_EXHAUST,    STEP_EMIT,  STEP_FOLW};
			STEP_FOLW:  u = '{OP_FOLLOW, C_OUTSIDE,    STEP_EMIT,  STEP_LEVEL};
			STEP_LEVEL: u = '{OP_LEVEL,  C_UPPER,      STEP_READ,  STEP_LEAF};
			STEP_LEAF:  u = '{OP_LEAF,   C_ALWAYS,     STEP_CHECK, STEP_CHECK};
			STEP_EMIT:  u = '{OP_EMIT,   C_OUT_FREE,   STEP_IDLE,  STEP_EMIT};
			default:    u = '{OP_NONE,   C_ALWAYS,     STEP_CLEAR, STEP_CLEAR};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

>>> sv/sv39pmb_ram.sv
// generic single-port ram with registered read
`default_nettype none
module sv39pmb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

>>> sv/sv39_page_mapping_builder.sv
// top level: microcoded sv39 page table builder over a local table pool
//
// channel   signals                                              direction
// in        in_valid/in_ready, virt_addr phys_addr page_count    into block
//           permission
// out       out_valid/out_ready, status pages_mapped             out of block
//           tables_in_use last_leaf
// cfg       cfg_wr_en, cfg_wr_data (table_base_page)             into block
//
// an item stops early on a full pool or a stray pointer; otherwise each page is
// two read/evaluate/follow passes and a leaf write through the one table ram port
// after reset a clearing pass zeroes the pool's 8192 entries, one entry a cycle,
// with in_ready low; configuration writes are taken throughout
// a new item may be accepted while the previous result waits on out_ready;
// the block then holds in its final step until the output register frees
`default_nettype none
module sv39_page_mapping_builder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [sv39pmb_pkg::PPN_W-1:0]  cfg_wr_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [sv39pmb_pkg::VA_W-1:0]   virt_addr,
	input  wire logic [sv39pmb_pkg::PA_W-1:0]   phys_addr,
	input  wire logic [sv39pmb_pkg::CNT_W-1:0]  page_count,
	input  wire logic [sv39pmb_pkg::FLAG_W-1:0] permission,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          status,
	output logic [sv39pmb_pkg::CNT_W-1:0]       pages_mapped,
	output logic [sv39pmb_pkg::USE_W-1:0]       tables_in_use,
	output logic [sv39pmb_pkg::PTE_W-1:0]       last_leaf
);

	sv39pmb_pkg::step_t step_q, step_nxt;
	sv39pmb_pkg::uop_t  uop;

	logic [sv39pmb_pkg::PPN_W-1:0]  base_q;
	logic [sv39pmb_pkg::ADDR_W-1:0] clr_q;
	logic [sv39pmb_pkg::PAGE_W-1:0] alloc_q;
	logic [sv39pmb_pkg::PAGE_W-1:0] page_q;
	logic                           sel_q;
	logic [sv39pmb_pkg::VA_W-1:0]   va_q;
	logic [sv39pmb_pkg::PA_W-1:0]   pa_q;
	logic [sv39pmb_pkg::CNT_W-1:0]  count_q;
	logic [sv39pmb_pkg::CNT_W-1:0]  done_q;
	logic [sv39pmb_pkg::FLAG_W-1:0] perm_q;
	logic [sv39pmb_pkg::PTE_W-1:0]  last_q;
	logic [sv39pmb_pkg::PTE_W-1:0]  entry_q;
	sv39pmb_pkg::status_t           status_q;
	sv39pmb_pkg::status_t           out_status_q;
	logic                           out_valid_q;
	logic [sv39pmb_pkg::CNT_W-1:0]  out_pages_q;
	logic [sv39pmb_pkg::USE_W-1:0]  out_use_q;
	logic [sv39pmb_pkg::PTE_W-1:0]  out_leaf_q;

	logic                           ram_we;
	logic [sv39pmb_pkg::ADDR_W-1:0] ram_addr;
	logic [sv39pmb_pkg::PTE_W-1:0]  ram_wdata;
	logic [sv39pmb_pkg::PTE_W-1:0]  ram_rdata;

	logic [sv39pmb_pkg::IDX_W-1:0]  walk_idx;
	logic [sv39pmb_pkg::IDX_W-1:0]  leaf_idx;
	logic [sv39pmb_pkg::PAGE_W-1:0] alloc_nxt;
	logic [sv39pmb_pkg::PPN_W-1:0]  new_ppn;
	logic [sv39pmb_pkg::PTE_W-1:0]  new_ptr;
	logic [sv39pmb_pkg::PTE_W-1:0]  leaf_pte;
	logic [sv39pmb_pkg::PPN_W-1:0]  rel_ppn;
	logic                           entry_zero;
	logic                           exhaust;
	logic                           outside;
	logic                           out_free;
	logic                           cond_hit;

	// datapath terms
	assign walk_idx   = sel_q ? va_q[29:21] : va_q[38:30];
	assign leaf_idx   = va_q[20:12];
	assign alloc_nxt  = alloc_q + 1'b1;
	assign new_ppn    = base_q + sv39pmb_pkg::PPN_W'(alloc_nxt);
	assign new_ptr    = {10'd0, new_ppn, 9'd0, 1'b1};
	assign leaf_pte   = {10'd0, pa_q[sv39pmb_pkg::PA_W-1:12], perm_q};
	assign rel_ppn    = entry_q[53:10] - base_q;
	assign entry_zero = (ram_rdata == '0);
	assign exhaust    = entry_zero &&
		(alloc_q == sv39pmb_pkg::PAGE_W'(sv39pmb_pkg::POOL_PAGES - 1));
	assign outside    = (rel_ppn >= sv39pmb_pkg::PPN_W'(sv39pmb_pkg::POOL_PAGES));
	assign out_free   = !out_valid_q || out_ready;

	// control word outputs
	always_comb begin
		uop       = sv39pmb_pkg::ucode(step_q);
		in_ready  = (uop.op == sv39pmb_pkg::OP_LOAD);
		ram_we    = 1'b0;
		ram_addr  = {page_q, walk_idx};
		ram_wdata = new_ptr;
		case (uop.op)
			sv39pmb_pkg::OP_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			sv39pmb_pkg::OP_EVAL: begin
				ram_we = entry_zero && !exhaust;
			end
			sv39pmb_pkg::OP_LEAF: begin
				ram_we    = 1'b1;
				ram_addr  = {page_q, leaf_idx};
				ram_wdata = leaf_pte;
			end
			default: begin
			end
		endcase
	end

	// next step
	always_comb begin
		case (uop.cond)
			sv39pmb_pkg::C_ALWAYS:     cond_hit = 1'b1;
			sv39pmb_pkg::C_CLR_LAST:
				cond_hit = (clr_q == sv39pmb_pkg::ADDR_W'(sv39pmb_pkg::STORE_DEPTH - 1));
			sv39pmb_pkg::C_ACCEPT:     cond_hit = in_valid;
			sv39pmb_pkg::C_COUNT_DONE: cond_hit = (done_q == count_q);
			sv39pmb_pkg::C_EXHAUST:    cond_hit = exhaust;
			sv39pmb_pkg::C_OUTSIDE:    cond_hit = outside;
			sv39pmb_pkg::C_UPPER:      cond_hit = !sel_q;
			sv39pmb_pkg::C_OUT_FREE:   cond_hit = out_free;
			default:                   cond_hit = 1'b1;
		endcase
		step_nxt = cond_hit ? uop.tgt_true : uop.tgt_false;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= sv39pmb_pkg::STEP_CLEAR;
			clr_q       <= '0;
			base_q      <= '0;
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (uop.op == sv39pmb_pkg::OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (uop.op)
				sv39pmb_pkg::OP_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				sv39pmb_pkg::OP_EVAL: begin
					if (entry_zero && !exhaust) begin
						alloc_q <= alloc_nxt;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (uop.op)
			sv39pmb_pkg::OP_LOAD: begin
				if (in_valid) begin
					va_q     <= virt_addr;
					pa_q     <= phys_addr;
					count_q  <= page_count;
					perm_q   <= permission;
					done_q   <= '0;
					last_q   <= '0;
					status_q <= sv39pmb_pkg::ST_DONE;
				end
			end
			sv39pmb_pkg::OP_PAGE: begin
				page_q <= '0;
				sel_q  <= 1'b0;
			end
			sv39pmb_pkg::OP_EVAL: begin
				if (!entry_zero) begin
					entry_q <= ram_rdata;
				end else if (exhaust) begin
					status_q <= sv39pmb_pkg::ST_EXHAUSTED;
				end else begin
					entry_q <= new_ptr;
				end
			end
			sv39pmb_pkg::OP_FOLLOW: begin
				if (outside) begin
					status_q <= sv39pmb_pkg::ST_OUTSIDE;
				end else begin
					page_q <= rel_ppn[sv39pmb_pkg::PAGE_W-1:0];
				end
			end
			sv39pmb_pkg::OP_LEVEL: begin
				sel_q <= 1'b1;
			end
			sv39pmb_pkg::OP_LEAF: begin
				last_q <= leaf_pte;
				done_q <= done_q + 1'b1;
				va_q   <= va_q + sv39pmb_pkg::VA_W'(sv39pmb_pkg::PAGE_BYTES);
				pa_q   <= pa_q + sv39pmb_pkg::PA_W'(sv39pmb_pkg::PAGE_BYTES);
			end
			sv39pmb_pkg::OP_EMIT: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_pages_q  <= done_q;
					out_use_q    <= sv39pmb_pkg::USE_W'(alloc_q);
					out_leaf_q   <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	sv39pmb_ram #(
		.WIDTH(sv39pmb_pkg::PTE_W),
		.DEPTH(sv39pmb_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign pages_mapped  = out_pages_q;
	assign tables_in_use = out_use_q;
	assign last_leaf     = out_leaf_q;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the sv39 page table builder: directed walks, then randomised mapping traffic
`timescale 1ns / 100ps
module tb;
	import sv39pmb_pkg::*;

	localparam int LIMIT_CYCLES  = 3_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_MAPS   = 1840;
	localparam int PHASES        = 8;
	localparam bit [PPN_W-1:0] HOME_BASE = 44'hFFF_FFFF_FFFA;

	typedef struct packed {
		status_t          st;
		logic [CNT_W-1:0] mapped;
		logic [USE_W-1:0] used;
		logic [PTE_W-1:0] leaf;
	} map_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [PPN_W-1:0]   cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VA_W-1:0]    virt_addr = '0;
	logic [PA_W-1:0]    phys_addr = '0;
	logic [CNT_W-1:0]   page_count = '0;
	logic [FLAG_W-1:0]  permission = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [CNT_W-1:0]   pages_mapped;
	logic [USE_W-1:0]   tables_in_use;
	logic [PTE_W-1:0]   last_leaf;

	bit [PTE_W-1:0]     pool_ram [STORE_DEPTH];
	int unsigned        pool_used;
	int unsigned        walk_page;
	bit [PPN_W-1:0]     table_base_shadow;
	map_result_t        mapping_outcomes [$];

	int    fail_count;
	int    maps_sent;
	int    results_seen;
	int    full_pool_stops;
	int    stray_stops;
	int    base_writes;
	int    burst_left;
	int    ready_left;
	int    cycle_count;
	longint pages_total;

	always #5 clk = ~clk;

	sv39_page_mapping_builder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.virt_addr    (virt_addr),
		.phys_addr    (phys_addr),
		.page_count   (page_count),
		.permission   (permission),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.pages_mapped (pages_mapped),
		.tables_in_use(tables_in_use),
		.last_leaf    (last_leaf)
	);

	// one level of the walk from walk_page; allocates a table when the entry is empty
	function automatic status_t follow_entry(input bit [IDX_W-1:0] idx);
		int unsigned    slot;
		bit [PTE_W-1:0] pte;
		bit [PPN_W-1:0] fresh;
		bit [PPN_W-1:0] rel;
		slot = walk_page * ENTRIES_PER_TABLE + idx;
		pte = pool_ram[slot];
		if (pte == '0) begin
			if (pool_used + 1 >= POOL_PAGES)
				return ST_EXHAUSTED;
			pool_used++;
			fresh = table_base_shadow + PPN_W'(pool_used);
			pte = {10'd0, fresh, 10'd1};
			pool_ram[slot] = pte;
		end
		rel = pte[PPN_W+9:10] - table_base_shadow;
		if (rel >= POOL_PAGES)
			return ST_OUTSIDE;
		walk_page = rel[31:0];
		return ST_DONE;
	endfunction

	function automatic map_result_t predict_mapping(input bit [VA_W-1:0] va_in,
			input bit [PA_W-1:0] pa_in, input bit [CNT_W-1:0] pages,
			input bit [FLAG_W-1:0] flags);
		map_result_t   r;
		bit [VA_W-1:0] va;
		bit [PA_W-1:0] pa;
		status_t       st;
		r = '{ST_DONE, '0, '0, '0};
		va = va_in;
		pa = pa_in;
		while (r.mapped < pages) begin
			walk_page = 0;
			st = follow_entry(va[38:30]);
			if (st == ST_DONE)
				st = follow_entry(va[29:21]);
			if (st != ST_DONE) begin
				r.st = st;
				break;
			end
			r.leaf = {54'd0, flags} + {10'd0, pa[PA_W-1:12], 10'd0};
			pool_ram[walk_page * ENTRIES_PER_TABLE + va[20:12]] = r.leaf;
			r.mapped = r.mapped + 1'b1;
			va = va + VA_W'(PAGE_BYTES);
			pa = pa + PA_W'(PAGE_BYTES);
		end
		r.used = pool_used[USE_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("result %0d: %s", results_seen, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin : collect
		map_result_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (mapping_outcomes.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = mapping_outcomes.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				if (pages_mapped !== want.mapped)
					report_mismatch($sformatf("pages_mapped %0d, expected %0d",
						pages_mapped, want.mapped));
				if (tables_in_use !== want.used)
					report_mismatch($sformatf("tables_in_use %0d, expected %0d",
						tables_in_use, want.used));
				if (last_leaf !== want.leaf)
					report_mismatch($sformatf("last_leaf %h, expected %h", last_leaf, want.leaf));
				if (want.st == ST_EXHAUSTED)
					full_pool_stops++;
				if (want.st == ST_OUTSIDE)
					stray_stops++;
				pages_total += want.mapped;
			end
			results_seen++;
		end
	end

	// receiver: ready runs and stalls of random length, now and then a long ready run
	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left--;
		end else if (out_ready) begin
			out_ready <= 1'b0;
			ready_left = $urandom_range(1, 12);
		end else begin
			out_ready <= 1'b1;
			ready_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("sv39_page_mapping_builder test failed");
			$finish;
		end
	end

	task automatic send_map(input bit [VA_W-1:0] va, input bit [PA_W-1:0] pa,
			input bit [CNT_W-1:0] pages, input bit [FLAG_W-1:0] flags);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
		end
		burst_left--;
		in_valid   <= 1'b1;
		virt_addr  <= va;
		phys_addr  <= pa;
		page_count <= pages;
		permission <= flags;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		mapping_outcomes.push_back(predict_mapping(va, pa, pages, flags));
		maps_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (mapping_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_table_base(input bit [PPN_W-1:0] ppn);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ppn;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		table_base_shadow = ppn;
		base_writes++;
	endtask

	task automatic test_zero_count();
		write_table_base(HOME_BASE);
		send_map('1, '1, 16'd0, '1);
		drain_results();
	endtask

	task automatic test_fresh_walk();
		send_map(39'h0, 56'h0, 16'd1, 10'h000);
		send_map(39'h1000, 56'hAB_CDEF_0123_4567, 16'd5, 10'h3ff);
		drain_results();
	endtask

	task automatic test_leaf_overwrite();
		send_map(39'h0, 56'h55_AAAA_5555_A000, 16'd2, 10'h155);
		drain_results();
	endtask

	task automatic test_address_wrap();
		send_map(39'h7F_FFFF_E000, 56'hFF_FFFF_FFFF_E000, 16'd4, 10'h2aa);
		drain_results();
	endtask

	task automatic test_region_crossing();
		send_map(39'h1F_F000, 56'h12_0000_0000_0000, 16'd2, 10'h0cf);
		send_map(39'h3FFF_F000, 56'h00_0000_7FFF_F000, 16'd2, 10'h301);
		drain_results();
	endtask

	task automatic test_pool_exhaustion();
		send_map(39'h1_4000_0000, 56'h00_0100_0000_0000, 16'd2560, 10'h0ef);
		send_map(39'h4B_0000_0000, 56'h00_0000_0000_1000, 16'd1, 10'h001);
		send_map(39'h1_4080_0000, 56'h80_0000_0000_0000, 16'hFFFF, 10'h200);
		drain_results();
	endtask

	// a root pointer seen from its own page: leaves land in the root and are then followed
	task automatic test_present_without_valid_bit();
		bit [PPN_W-1:0] root_ptr;
		root_ptr = pool_ram[0][PPN_W+9:10];
		write_table_base(root_ptr);
		send_map(39'h7000, {root_ptr, 12'h000}, 16'd1, 10'h00e);
		send_map(39'h1_C000_9000, 56'h12_3456_789A_B000, 16'd1, 10'h3c5);
		drain_results();
	endtask

	task automatic test_outside_pool();
		write_table_base('0);
		send_map(39'h0, 56'h00_0000_00AB_0000, 16'd3, 10'h001);
		write_table_base('1);
		send_map(39'h7F_FFE0_0000, 56'h0, 16'd2, 10'h3ff);
		drain_results();
	endtask

	task automatic test_random_traffic();
		bit [VA_W-1:0]  regions [10];
		bit [PPN_W-1:0] phase_base [PHASES];
		bit [VA_W-1:0]  va;
		bit [PA_W-1:0]  pa;
		bit [CNT_W-1:0] pages;
		int             pick;
		regions = '{39'h0, 39'h20_0000, 39'h3FE0_0000, 39'h4000_0000, 39'h7F_FFE0_0000,
			39'h1_4000_0000, 39'h1_4020_0000, 39'h1_4040_0000, 39'h1_4060_0000,
			39'h1_4080_0000};
		phase_base[0] = HOME_BASE;
		phase_base[1] = HOME_BASE;
		phase_base[2] = HOME_BASE + 3;
		phase_base[3] = PPN_W'({$urandom, $urandom});
		phase_base[4] = HOME_BASE;
		phase_base[5] = '0;
		phase_base[6] = '1;
		phase_base[7] = HOME_BASE - 1;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_table_base(phase_base[ph]);
			for (int n = 0; n < RANDOM_MAPS / PHASES; n++) begin
				if ($urandom_range(0, 3) != 0) begin
					va = regions[$urandom_range(0, 9)];
					va[20:0] = 21'($urandom);
				end else begin
					va = VA_W'({$urandom, $urandom});
				end
				pa = PA_W'({$urandom, $urandom});
				if ($urandom_range(0, 4) == 0)
					pa[PA_W-1:12] = table_base_shadow + PPN_W'($urandom_range(0, 15));
				pick = $urandom_range(0, 99);
				if (pick < 8)
					pages = '0;
				else if (pick < 80)
					pages = CNT_W'($urandom_range(1, 8));
				else if (pick < 98)
					pages = CNT_W'($urandom_range(9, 80));
				else
					pages = CNT_W'($urandom_range(300, 700));
				send_map(va, pa, pages, FLAG_W'($urandom));
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_count();
		test_fresh_walk();
		test_leaf_overwrite();
		test_address_wrap();
		test_region_crossing();
		test_pool_exhaustion();
		test_present_without_valid_bit();
		test_outside_pool();
		test_random_traffic();
		drain_results();
		$display("%0d mapping requests checked, %0d stopped on a full pool, %0d on a stray pointer",
			maps_sent, full_pool_stops, stray_stops);
		$display("table base moved %0d times, %0d leaf entries written in all",
			base_writes, pages_total);
		if (fail_count == 0)
			$display("sv39_page_mapping_builder test passed");
		else
			$display("sv39_page_mapping_builder test failed");
		$finish;
	end

endmodule
